// ===== src/bdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_pkg: shared definitions for the bounded deque
// Sizes, operation codes and the per-cell command used by the cell row.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH  = 16;
	localparam int WORD_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 5;
	localparam int FUNC_W = 3;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INS_REAR  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DEL_REAR  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_PEEK      = 3'd4;

	localparam logic [0:0] REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic ins_front;
		logic ins_rear;
		logic del_front;
		logic del_rear;
	} cell_op_t;

endpackage
`default_nettype wire

// ===== src/bdq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdq_cell: one position of the deque
// Holds one word and its valid flag and trades data with its neighbors.
// ----------------------------------------------------------------------------
module bdq_cell (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire bdq_pkg::cell_op_t         op,
	input  wire  [bdq_pkg::WORD_W-1:0]     value,
	input  wire                            prev_valid,
	input  wire  [bdq_pkg::WORD_W-1:0]     prev_data,
	input  wire                            next_valid,
	input  wire  [bdq_pkg::WORD_W-1:0]     next_data,
	output logic                           valid,
	output logic [bdq_pkg::WORD_W-1:0]     data,
	output logic [bdq_pkg::WORD_W-1:0]     rear_data
);

	logic                          valid_q;
	logic [bdq_pkg::WORD_W-1:0]    data_q;
	logic                          valid_d;
	logic [bdq_pkg::WORD_W-1:0]    data_d;

	always_comb begin
		valid_d = valid_q;
		data_d  = data_q;
		priority if (op.ins_front) begin
			valid_d = prev_valid;
			data_d  = prev_data;
		end else if (op.ins_rear) begin
			if (!valid_q && prev_valid) begin
				valid_d = 1'b1;
				data_d  = value;
			end
		end else if (op.del_front) begin
			valid_d = next_valid;
			data_d  = next_data;
		end else if (op.del_rear) begin
			if (valid_q && !next_valid) begin
				valid_d = 1'b0;
			end
		end else begin
			valid_d = valid_q;
			data_d  = data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign valid     = valid_q;
	assign data      = data_q;
	assign rear_data = (valid_q && !next_valid) ? data_q : '0;

endmodule
`default_nettype wire

// ===== src/bounded_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is offered in the cycle after its item is accepted.
// Throughput: one item per cycle while the input is not stalled; every cell of the row updates in the same cycle.
// The input stalls only while a result waits at a stalled output.
// Reset empties the deque, sets capacity to 16 and drops any pending result.
// Word contents are not reset; only cells marked valid are ever shown.
// ----------------------------------------------------------------------------
// bounded_deque: double-ended queue in a row of shifting cells
// Cell 0 holds the front word; inserts and deletes at the front shift the row.
// ----------------------------------------------------------------------------
module bounded_deque (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire  [bdq_pkg::ADDR_W-1:0]        paddr,
	input  wire  [bdq_pkg::DATA_W-1:0]        pwdata,
	output logic [bdq_pkg::DATA_W-1:0]        prdata,
	output logic                              pready,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [bdq_pkg::FUNC_W-1:0]        func,
	input  wire signed [bdq_pkg::WORD_W-1:0]  value,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              ok,
	output logic signed [bdq_pkg::WORD_W-1:0] front_word,
	output logic signed [bdq_pkg::WORD_W-1:0] rear_word,
	output logic                              is_empty,
	output logic                              is_full,
	output logic [bdq_pkg::CNT_W-1:0]         held
);

	localparam int N = bdq_pkg::DEPTH;

	logic [bdq_pkg::CAP_W-1:0]  cap_q;
	logic [bdq_pkg::CNT_W-1:0]  held_q;
	logic                       ok_q;
	logic                       out_valid_q;
	logic [bdq_pkg::CNT_W-1:0]  eff_cap;
	logic                       in_acc;
	logic                       ok_c;
	logic                       has_room;
	logic                       has_word;
	bdq_pkg::cell_op_t          op;
	logic [N-1:0]               cell_valid;
	logic [bdq_pkg::WORD_W-1:0] cell_data [N];
	logic [bdq_pkg::WORD_W-1:0] cell_rear [N];
	logic [bdq_pkg::WORD_W-1:0] rear_or;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= bdq_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && pready &&
			paddr[bdq_pkg::ADDR_W-1] == bdq_pkg::REG_CAPACITY) begin
			cap_q <= pwdata[bdq_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr[bdq_pkg::ADDR_W-1] == bdq_pkg::REG_CAPACITY) ?
		bdq_pkg::DATA_W'(cap_q) : '0;

	assign eff_cap  = (cap_q > bdq_pkg::CAP_W'(N)) ? bdq_pkg::CNT_W'(N) :
		bdq_pkg::CNT_W'(cap_q);
	assign has_room = held_q < eff_cap;
	assign has_word = held_q != '0;
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	always_comb begin
		ok_c = 1'b0;
		op   = '0;
		unique case (func)
			bdq_pkg::FN_INS_FRONT: begin
				ok_c         = has_room;
				op.ins_front = in_acc && has_room;
			end
			bdq_pkg::FN_INS_REAR: begin
				ok_c        = has_room;
				op.ins_rear = in_acc && has_room;
			end
			bdq_pkg::FN_DEL_FRONT: begin
				ok_c         = has_word;
				op.del_front = in_acc && has_word;
			end
			bdq_pkg::FN_DEL_REAR: begin
				ok_c        = has_word;
				op.del_rear = in_acc && has_word;
			end
			bdq_pkg::FN_PEEK: begin
				ok_c = 1'b1;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (op.ins_front || op.ins_rear) begin
				held_q <= held_q + bdq_pkg::CNT_W'(1);
			end else if (op.del_front || op.del_rear) begin
				held_q <= held_q - bdq_pkg::CNT_W'(1);
			end
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ok_q <= ok_c;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic                       pv;
		logic [bdq_pkg::WORD_W-1:0] pd;
		logic                       nv;
		logic [bdq_pkg::WORD_W-1:0] nd;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
			assign pd = value;
		end else begin : g_mid
			assign pv = cell_valid[i-1];
			assign pd = cell_data[i-1];
		end
		if (i == N - 1) begin : g_last
			assign nv = 1'b0;
			assign nd = '0;
		end else begin : g_inner
			assign nv = cell_valid[i+1];
			assign nd = cell_data[i+1];
		end
		bdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.op         (op),
			.value      (value),
			.prev_valid (pv),
			.prev_data  (pd),
			.next_valid (nv),
			.next_data  (nd),
			.valid      (cell_valid[i]),
			.data       (cell_data[i]),
			.rear_data  (cell_rear[i])
		);
	end

	always_comb begin
		rear_or = '0;
		for (int i = 0; i < N; i++) begin
			rear_or = rear_or | cell_rear[i];
		end
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign front_word = cell_valid[0] ? cell_data[0] : '1;
	assign rear_word  = cell_valid[0] ? rear_or : '1;
	assign is_empty   = held_q == '0;
	assign is_full    = held_q == eff_cap;
	assign held       = held_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(cell_valid) == 32'(held_q))
		else $error("held count disagrees with valid cells");

	a_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + N'(1)) & cell_valid) == '0)
		else $error("valid cells are not packed from the front");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(op.ins_front || op.ins_rear) |=> held_q == $past(held_q) + bdq_pkg::CNT_W'(1))
		else $error("successful insert did not grow the count");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= bdq_pkg::CNT_W'(N))
		else $error("count exceeds the number of cells");

endmodule
`default_nettype wire
